@@ sv/kep_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keystroke entropy pool package
// Shared widths, codes, control word layout and the microcode program.
// ----------------------------------------------------------------------------
package kep_pkg;

  localparam int POOL_SIZE_DEF = 16;
  localparam int CFG_W         = 16;
  localparam int KEY_W         = 8;
  localparam int TS_W          = 32;
  localparam int WAIT_W        = 8;
  localparam int VAL_W         = 32;
  localparam int PROG_W        = 5;
  localparam int S_TDATA_W     = 48;
  localparam int M_TDATA_W     = 40;

  localparam logic [CFG_W-1:0] THRESH_RESET = 16'd64;
  localparam logic [CFG_W-1:0] USE_MAX      = 16'hFFFF;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_NEED   = 2'd1,
    ST_SAMPLE = 2'd2,
    ST_IGNORE = 2'd3
  } status_t;

  typedef logic [3:0] pc_t;

  localparam pc_t PC_IDLE   = 4'd0;
  localparam pc_t PC_EMIT   = 4'd1;
  localparam pc_t PC_STORE  = 4'd2;
  localparam pc_t PC_MIX_RD = 4'd3;
  localparam pc_t PC_MIX_WR = 4'd4;
  localparam pc_t PC_FIN    = 4'd5;
  localparam pc_t PC_RD01   = 4'd6;
  localparam pc_t PC_RD23   = 4'd7;
  localparam pc_t PC_ACC    = 4'd8;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_FILL_MORE,
    COND_MIX_MORE,
    COND_DISPATCH
  } cond_t;

  typedef enum logic [1:0] {
    ASEL_NONE,
    ASEL_MIX,
    ASEL_RD01,
    ASEL_RD23
  } asel_t;

  typedef enum logic [1:0] {
    WS_NONE,
    WS_SAMPLE,
    WS_MIX
  } wsel_t;

  typedef struct packed {
    logic  wait_in;
    asel_t asel;
    wsel_t wsel;
    logic  acc_ld;
    logic  idx_clr;
    logic  idx_inc;
    logic  fin;
    logic  emit;
    cond_t cond;
    pc_t   target;
  } ucw_t;

  typedef struct packed {
    logic accept;
    pc_t  entry;
    logic fill_more;
    logic mix_more;
    logic out_free;
  } dp_flags_t;

  function automatic ucw_t ucode(input pc_t pc);
    ucw_t w;
    w = '0;
    unique case (pc)
      PC_IDLE: begin
        w.wait_in = 1'b1;
        w.cond    = COND_DISPATCH;
      end
      PC_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = PC_IDLE;
      end
      PC_STORE: begin
        w.wsel    = WS_SAMPLE;
        w.idx_clr = 1'b1;
        w.cond    = COND_FILL_MORE;
        w.target  = PC_EMIT;
      end
      PC_MIX_RD: begin
        w.asel = ASEL_MIX;
      end
      PC_MIX_WR: begin
        w.wsel    = WS_MIX;
        w.idx_inc = 1'b1;
        w.cond    = COND_MIX_MORE;
        w.target  = PC_MIX_RD;
      end
      PC_FIN: begin
        w.fin    = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = PC_EMIT;
      end
      PC_RD01: begin
        w.asel = ASEL_RD01;
      end
      PC_RD23: begin
        w.asel   = ASEL_RD23;
        w.acc_ld = 1'b1;
      end
      PC_ACC: begin
        w.acc_ld = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = PC_EMIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ sv/kep_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keystroke entropy pool sequencer
// Step counter over the microcode program with conditional jumps and dispatch.
// ----------------------------------------------------------------------------
module kep_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire kep_pkg::dp_flags_t flags,
  output kep_pkg::ucw_t           cw
);
  import kep_pkg::*;

  pc_t pc;
  pc_t pc_next;

  assign cw = ucode(pc);

  always_comb begin
    pc_next = pc_t'(pc + 1'b1);
    unique case (cw.cond)
      COND_NEXT: ;
      COND_ALWAYS: pc_next = cw.target;
      COND_FILL_MORE: if (flags.fill_more) pc_next = cw.target;
      COND_MIX_MORE: if (flags.mix_more) pc_next = cw.target;
      COND_DISPATCH: pc_next = flags.accept ? flags.entry : pc;
      default: pc_next = PC_IDLE;
    endcase
    if (cw.emit && !flags.out_free) pc_next = pc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/kep_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keystroke entropy pool datapath
// Pool memory, fill and use bookkeeping, word assembly and output register.
// ----------------------------------------------------------------------------
module kep_datapath #(
  parameter int POOL_SIZE = kep_pkg::POOL_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire kep_pkg::ucw_t                  cw,
  output kep_pkg::dp_flags_t                  flags,
  input  wire logic                           cfg_wr_en,
  input  wire logic [kep_pkg::CFG_W-1:0]      cfg_wr_data,
  input  wire logic                           s_tvalid,
  input  wire logic [kep_pkg::S_TDATA_W-1:0]  s_tdata,
  input  wire logic                           s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [kep_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic [1:0]                          m_tuser
);
  import kep_pkg::*;

  localparam int AW = $clog2(POOL_SIZE);
  localparam int FW = $clog2(POOL_SIZE + 1);
  localparam int SW = AW + 2;

  function automatic logic [AW-1:0] wrap_addr(input logic [SW-1:0] v);
    logic [SW-1:0] r;
    r = (v >= SW'(POOL_SIZE)) ? v - SW'(POOL_SIZE) : v;
    return r[AW-1:0];
  endfunction

  logic [7:0]        pool_mem [POOL_SIZE];
  logic [CFG_W-1:0]  thr;
  logic [CFG_W-1:0]  use_count;
  logic [FW-1:0]     fill_index;
  logic              collecting;
  logic              initialized;
  logic [AW-1:0]     idx;
  logic [KEY_W-1:0]  key_q;
  logic [TS_W-1:0]   ts_q;
  logic [WAIT_W-1:0] wait_q;
  status_t           stat_q;
  status_t           stat_d;
  logic [VAL_W-1:0]  acc;
  logic [7:0]        qa;
  logic [7:0]        qb;
  logic [VAL_W-1:0]  out_val;
  logic [PROG_W-1:0] out_prog;
  logic              out_rdy;
  status_t           out_stat;

  logic              accept;
  logic              out_free;
  logic              start_fill;
  logic              serve;
  pc_t               entry;
  logic [AW-1:0]     off_m;
  logic [AW-1:0]     ra;
  logic [AW-1:0]     rb;
  logic [AW-1:0]     wa;
  logic [7:0]        wd;
  logic              we;
  logic              rd_en;
  logic [7:0]        sample;

  assign accept   = s_tvalid && cw.wait_in;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    start_fill = 1'b0;
    serve      = 1'b0;
    entry      = PC_EMIT;
    stat_d     = ST_IGNORE;
    if (s_tuser == CMD_KEY) begin
      if (collecting && (fill_index < FW'(POOL_SIZE))) begin
        stat_d = ST_SAMPLE;
        entry  = PC_STORE;
      end
    end else if (collecting) begin
      stat_d = ST_NEED;
    end else if (!initialized || (use_count >= thr)) begin
      stat_d     = ST_NEED;
      start_fill = 1'b1;
    end else begin
      stat_d = ST_VALID;
      serve  = 1'b1;
      entry  = PC_RD01;
    end
  end

  assign flags.accept    = accept;
  assign flags.entry     = entry;
  assign flags.fill_more = (fill_index != FW'(POOL_SIZE - 1));
  assign flags.mix_more  = (idx != AW'(POOL_SIZE - 1));
  assign flags.out_free  = out_free;

  assign sample = key_q ^ ts_q[7:0] ^ ts_q[15:8] ^ ts_q[23:16] ^ wait_q;
  assign off_m  = wrap_addr(SW'(ts_q[3:0]));

  always_comb begin
    ra = idx;
    rb = wrap_addr(SW'(idx) + SW'(7));
    case (cw.asel)
      ASEL_RD01: begin
        ra = off_m;
        rb = wrap_addr(SW'(off_m) + SW'(1));
      end
      ASEL_RD23: begin
        ra = wrap_addr(SW'(off_m) + SW'(2));
        rb = wrap_addr(SW'(off_m) + SW'(3));
      end
      default: ;
    endcase
  end

  assign rd_en = (cw.asel != ASEL_NONE);
  assign we    = (cw.wsel != WS_NONE);
  assign wa    = (cw.wsel == WS_SAMPLE) ? fill_index[AW-1:0] : idx;
  assign wd    = (cw.wsel == WS_SAMPLE) ? sample : (qa ^ qb);

  always_ff @(posedge clk) begin
    if (we) pool_mem[wa] <= wd;
    if (rd_en) begin
      qa <= pool_mem[ra];
      qb <= pool_mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr         <= THRESH_RESET;
      use_count   <= '0;
      fill_index  <= '0;
      collecting  <= 1'b0;
      initialized <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_wr_en) thr <= cfg_wr_data;
      if (accept && start_fill) begin
        collecting <= 1'b1;
        fill_index <= '0;
      end
      if (accept && serve && (use_count != USE_MAX)) use_count <= use_count + 1'b1;
      if (cw.wsel == WS_SAMPLE) fill_index <= fill_index + 1'b1;
      if (cw.fin) begin
        collecting  <= 1'b0;
        initialized <= 1'b1;
        use_count   <= '0;
      end
      if (cw.emit && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q  <= s_tdata[7:0];
      ts_q   <= s_tdata[39:8];
      wait_q <= s_tdata[47:40];
      stat_q <= stat_d;
    end
    if (cw.idx_clr) begin
      idx <= '0;
    end else if (cw.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (cw.acc_ld) acc <= {acc[15:0], qa, qb};
    if (cw.emit && out_free) begin
      out_stat <= stat_q;
      out_val  <= (stat_q == ST_VALID) ? (acc ^ ts_q) : '0;
      out_prog <= PROG_W'(fill_index);
      out_rdy  <= initialized && !collecting;
    end
  end

  assign m_tdata = {2'b00, out_rdy, out_prog, out_val};
  assign m_tuser = out_stat;

endmodule
`default_nettype wire

@@ sv/keystroke_entropy_pool.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keystroke entropy pool
// Collects key samples into a byte pool, mixes it and serves 32-bit words.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields
// s_*       in   tuser: cmd; tdata: key_code[7:0] time_stamp[39:8] wait_count[47:40]
// m_*       out  tuser: status; tdata: random_value[31:0] fill_progress[36:32]
//                pool_ready[37]
// cfg_*     in   refresh_threshold write, one register
//
// An ignored sample or a need-entropy answer goes from dispatch to the emit step, and
// a stored sample passes the store step first. A served read passes two read steps of
// the dual-port pool memory and an accumulate step. The last sample of a fill runs the
// mixing pass, which reads and writes each pool entry in a read step and a write step,
// then the finish step. Reset clears no memory. A stalled output holds the emit step.
// ----------------------------------------------------------------------------
module keystroke_entropy_pool #(
  parameter int POOL_SIZE = kep_pkg::POOL_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [kep_pkg::CFG_W-1:0]     cfg_wr_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // key_code[7:0], time_stamp[39:8], wait_count[47:40]
  input  wire logic [kep_pkg::S_TDATA_W-1:0] s_tdata,
  // cmd[0]
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // random_value[31:0], fill_progress[36:32], pool_ready[37], zeros[39:38]
  output logic [kep_pkg::M_TDATA_W-1:0]      m_tdata,
  // status[1:0]
  output logic [1:0]                         m_tuser
);
  import kep_pkg::*;

  ucw_t      cw;
  dp_flags_t flags;

  assign s_tready = cw.wait_in;

  kep_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  kep_datapath #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cw          (cw),
    .flags       (flags),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule
`default_nettype wire

@@ sv/kep_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keystroke entropy pool checker
// Port-level properties of the pool, bound to the top level.
// ----------------------------------------------------------------------------
module kep_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [1:0]  m_tuser
);
  import kep_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Output transaction changed while stalled.");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_VALID) |-> (m_tdata[31:0] == 32'd0))
    else $error("Random value is nonzero on a non-value status.");

  a_value_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_VALID) |-> m_tdata[37])
    else $error("Value served while the pool is not ready.");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input accepted while the previous transaction is in progress.");

endmodule

bind keystroke_entropy_pool kep_checker u_kep_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keystroke entropy pool testbench
// Drives key samples and read requests into the stream input and works out
// each answer with a local model of the pool, its fill and mixing pass and
// its use count. Every output transaction is checked against the oldest
// expected answer. Both sides idle at random, and the refresh threshold is
// moved through its extremes between phases.
// ----------------------------------------------------------------------------
module tb;
  import kep_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
    logic [4:0]  progress;
    logic        ready;
  } pool_answer_t;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;
  logic                   s_tvalid    = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata     = '0;
  logic                   s_tuser     = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready    = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [1:0]             m_tuser;

  // Local copy of the block state.
  logic [7:0]       pool_bytes [POOL_SIZE_DEF];
  logic [4:0]       fill_idx    = '0;
  logic             collecting  = 1'b0;
  logic             initialized = 1'b0;
  logic [CFG_W-1:0] use_count   = '0;
  logic [CFG_W-1:0] threshold   = THRESH_RESET;

  pool_answer_t expected_answers [$];
  status_t      last_status;
  int           error_count = 0;
  int           cycle_count = 0;
  int           stall_len   = 0;
  bit           tx_idle_on  = 1'b1;
  bit           rx_idle_on  = 1'b1;

  keystroke_entropy_pool i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic predict_pool_answer(input logic cmd, input logic [7:0] key,
                                     input logic [31:0] ts, input logic [7:0] wt,
                                     output pool_answer_t ans);
    logic [31:0] word;
    int          i;
    ans  = '0;
    word = '0;
    if (cmd == CMD_KEY) begin
      if (!collecting || fill_idx >= POOL_SIZE_DEF) begin
        ans.status = ST_IGNORE;
      end else begin
        pool_bytes[fill_idx[3:0]] = key ^ ts[7:0] ^ ts[15:8] ^ ts[23:16] ^ wt;
        fill_idx = fill_idx + 5'd1;
        if (fill_idx >= POOL_SIZE_DEF) begin
          for (i = 0; i < POOL_SIZE_DEF; i++) begin
            pool_bytes[4'(i)] = pool_bytes[4'(i)] ^
                                pool_bytes[4'((i + 7) % POOL_SIZE_DEF)];
          end
          collecting  = 1'b0;
          initialized = 1'b1;
          use_count   = '0;
        end
        ans.status = ST_SAMPLE;
      end
    end else if (collecting) begin
      ans.status = ST_NEED;
    end else if (!initialized || use_count >= threshold) begin
      collecting = 1'b1;
      fill_idx   = '0;
      ans.status = ST_NEED;
    end else begin
      if (use_count != USE_MAX) begin
        use_count = use_count + 1'b1;
      end
      for (i = 0; i < 4; i++) begin
        word = {word[23:0], pool_bytes[4'((int'(ts[3:0]) + i) % POOL_SIZE_DEF)]};
      end
      ans.status = ST_VALID;
      ans.value  = word ^ ts;
    end
    ans.progress = fill_idx;
    ans.ready    = initialized && !collecting;
  endtask

  // Output checker: one expected answer per output transaction.
  always @(posedge clk) begin
    pool_answer_t exp_ans;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_answers.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result: status %0d tdata %h", m_tuser, m_tdata);
        end
      end else begin
        exp_ans = expected_answers.pop_front();
        if (m_tuser != exp_ans.status || m_tdata[31:0] != exp_ans.value ||
            m_tdata[36:32] != exp_ans.progress || m_tdata[37] != exp_ans.ready ||
            m_tdata[39:38] != 2'b00) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch (expected/actual): status %0d/%0d value %h/%h",
                     exp_ans.status, m_tuser, exp_ans.value, m_tdata[31:0]);
            $display("  progress %0d/%0d ready %0d/%0d pad 0/%0d",
                     exp_ans.progress, m_tdata[36:32], exp_ans.ready, m_tdata[37],
                     m_tdata[39:38]);
          end
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    forever begin
      if (stall_len != 0) begin
        m_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
        stall_len = 0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat (rx_idle_on ? $urandom_range(1, 24) : 1) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] key,
                           input logic [31:0] ts, input logic [7:0] wt);
    pool_answer_t ans;
    s_tuser  <= cmd;
    s_tdata  <= {wt, ts, key};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_pool_answer(cmd, key, ts, wt, ans);
    expected_answers.push_back(ans);
    last_status = ans.status;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold = value;
    @(posedge clk);
  endtask

  // Mostly well-formed traffic: samples while a fill runs, reads otherwise.
  task automatic run_random(input int count);
    int          taken;
    logic        cmd;
    logic [31:0] ts;
    taken = 0;
    while (taken < count) begin
      if (collecting) begin
        cmd = ($urandom_range(0, 9) == 0) ? CMD_READ : CMD_KEY;
      end else begin
        cmd = ($urandom_range(0, 7) == 0) ? CMD_KEY : CMD_READ;
      end
      case ($urandom_range(0, 9))
        0: ts = '0;
        1: ts = '1;
        default: ts = $urandom;
      endcase
      send_item(cmd, 8'($urandom_range(0, 255)), ts, 8'($urandom_range(0, 255)));
      if (last_status != ST_IGNORE) begin
        taken++;
      end
    end
  endtask

  task automatic test_directed();
    int i;
    send_item(CMD_KEY, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(CMD_READ, 8'h00, 32'h0000_0000, 8'h00);
    send_item(CMD_READ, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    for (i = 0; i < POOL_SIZE_DEF; i++) begin
      send_item(CMD_KEY, (i % 2 != 0) ? 8'hFF : 8'h00,
                ((i % 4 < 2) ? 32'h0000_0000 : 32'hFFFF_FFFF) ^ (32'(i) << (2 * i)),
                (i % 3 == 0) ? 8'hFF : 8'h00);
    end
    send_item(CMD_KEY, 8'h5A, 32'h8000_0001, 8'hA5);
    send_item(CMD_READ, 8'h00, 32'h0000_0000, 8'h00);
    send_item(CMD_READ, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(CMD_READ, 8'h00, 32'h1234_567D, 8'h00);
  endtask

  task automatic test_threshold_one();
    int i;
    write_threshold(16'd1);
    send_item(CMD_READ, 8'h00, $urandom, 8'h00);
    for (i = 0; i < POOL_SIZE_DEF; i++) begin
      send_item(CMD_KEY, 8'($urandom_range(0, 255)), $urandom, 8'($urandom_range(0, 255)));
    end
    send_item(CMD_READ, 8'h00, $urandom, 8'h00);
    send_item(CMD_READ, 8'h00, $urandom, 8'h00);
    run_random(150);
  endtask

  task automatic test_threshold_zero();
    write_threshold(16'd0);
    run_random(150);
  endtask

  task automatic test_threshold_max();
    write_threshold(16'hFFFF);
    run_random(250);
  endtask

  task automatic test_backpressure();
    write_threshold(16'($urandom_range(2, 20)));
    tx_idle_on = 1'b0;
    stall_len  = 300;
    run_random(30);
    wait_drained();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_thresholds();
    int k;
    for (k = 0; k < 4; k++) begin
      write_threshold((k == 0) ? THRESH_RESET : 16'($urandom_range(2, 64)));
      run_random(150);
    end
  endtask

  task automatic test_no_idle();
    write_threshold(16'($urandom_range(1, 8)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(250);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_threshold_one();
    test_threshold_zero();
    test_threshold_max();
    test_backpressure();
    test_random_thresholds();
    test_no_idle();
    wait_drained();
    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
